/* rtl/http_request_head_parser_defines.svh */
// Assertion macros used by the RTL.
`ifndef HTTP_REQUEST_HEAD_PARSER_DEFINES_SVH
`define HTTP_REQUEST_HEAD_PARSER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HRP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define HRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/hrp_pkg.sv */
package hrp_pkg;

    localparam int unsigned VERSION_MAX = 999;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       restart;
    } in_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [1:0]  method_code;
        logic [11:0] first_start;
        logic [11:0] first_end;
        logic [11:0] second_start;
        logic [11:0] second_end;
        logic [9:0]  version_major;
        logic [9:0]  version_minor;
    } out_t;

    typedef struct packed {
        logic valid;
        out_t data;
    } res_t;

    localparam logic [2:0] EV_LINE        = 3'd0;
    localparam logic [2:0] EV_HEADER      = 3'd1;
    localparam logic [2:0] EV_END         = 3'd2;
    localparam logic [2:0] EV_BAD_METHOD  = 3'd3;
    localparam logic [2:0] EV_BAD_REQUEST = 3'd4;
    localparam logic [2:0] EV_BAD_HEADER  = 3'd5;

    localparam logic [1:0] M_UNKNOWN = 2'd0;
    localparam logic [1:0] M_GET     = 2'd1;
    localparam logic [1:0] M_HEAD    = 2'd2;
    localparam logic [1:0] M_POST    = 2'd3;

    localparam logic [23:0] WORD_GET  = 24'h474554;
    localparam logic [31:0] WORD_HEAD = 32'h48454144;
    localparam logic [31:0] WORD_POST = 32'h504F5354;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;

    function automatic logic [9:0] ver_acc(input logic [9:0] acc, input logic [7:0] c);
        logic [13:0] v;
        v = 14'(acc) * 14'd10 + 14'(c[3:0]);
        return (v > 14'(VERSION_MAX)) ? 10'(VERSION_MAX) : v[9:0];
    endfunction

endpackage

/* rtl/hrp_parser.sv */
module hrp_parser (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  hrp_pkg::in_t item,
    output hrp_pkg::res_t res
);
    import hrp_pkg::*;

    localparam logic [4:0] S_START     = 5'd0;
    localparam logic [4:0] S_METHOD    = 5'd1;
    localparam logic [4:0] S_SP_URI    = 5'd2;
    localparam logic [4:0] S_URI       = 5'd3;
    localparam logic [4:0] S_VH        = 5'd4;
    localparam logic [4:0] S_VHT       = 5'd5;
    localparam logic [4:0] S_VHTT      = 5'd6;
    localparam logic [4:0] S_VHTTP     = 5'd7;
    localparam logic [4:0] S_VSLASH    = 5'd8;
    localparam logic [4:0] S_MAJ_FIRST = 5'd9;
    localparam logic [4:0] S_MAJ       = 5'd10;
    localparam logic [4:0] S_MIN_FIRST = 5'd11;
    localparam logic [4:0] S_MIN       = 5'd12;
    localparam logic [4:0] S_SP_AFTER  = 5'd13;
    localparam logic [4:0] S_ALMOST    = 5'd14;
    localparam logic [4:0] S_LINE      = 5'd15;
    localparam logic [4:0] S_KEY       = 5'd16;
    localparam logic [4:0] S_SP_COLON  = 5'd17;
    localparam logic [4:0] S_SP_VALUE  = 5'd18;
    localparam logic [4:0] S_VALUE     = 5'd19;
    localparam logic [4:0] S_CR        = 5'd20;
    localparam logic [4:0] S_CRLFCR    = 5'd21;
    localparam logic [4:0] S_DONE      = 5'd22;
    localparam logic [4:0] S_ERROR     = 5'd23;

    logic [4:0]  state_reg, state_next, cur_state;
    logic [11:0] offset_reg, offset_next, off;
    logic [31:0] mchars_reg, mchars_next, cur_mchars;
    logic [2:0]  mlen_reg, mlen_next, cur_mlen;
    logic [1:0]  mkind_reg, mkind_next, cur_mkind;
    logic [11:0] uri_begin_reg, uri_begin_next, cur_uri_begin;
    logic [11:0] uri_finish_reg, uri_finish_next, cur_uri_finish;
    logic [9:0]  major_reg, major_next, cur_major;
    logic [9:0]  minor_reg, minor_next, cur_minor;
    logic [11:0] key_begin_reg, key_begin_next, cur_key_begin;
    logic [11:0] key_finish_reg, key_finish_next, cur_key_finish;
    logic [11:0] value_begin_reg, value_begin_next, cur_value_begin;
    logic [11:0] value_finish_reg, value_finish_next, cur_value_finish;

    logic [7:0] c;
    logic       is_digit, is_upper;
    logic       emit;
    logic [2:0] emit_kind;
    logic [1:0] method_class;

    assign c        = item.byte_in;
    assign is_digit = (c >= CH_0) && (c <= CH_9);
    assign is_upper = (c >= CH_UA) && (c <= CH_UZ);

    always_comb begin
        if (item.restart) begin
            cur_state        = S_START;
            off              = '0;
            cur_mchars       = '0;
            cur_mlen         = '0;
            cur_mkind        = M_UNKNOWN;
            cur_uri_begin    = '0;
            cur_uri_finish   = '0;
            cur_major        = '0;
            cur_minor        = '0;
            cur_key_begin    = '0;
            cur_key_finish   = '0;
            cur_value_begin  = '0;
            cur_value_finish = '0;
        end else begin
            cur_state        = state_reg;
            off              = offset_reg;
            cur_mchars       = mchars_reg;
            cur_mlen         = mlen_reg;
            cur_mkind        = mkind_reg;
            cur_uri_begin    = uri_begin_reg;
            cur_uri_finish   = uri_finish_reg;
            cur_major        = major_reg;
            cur_minor        = minor_reg;
            cur_key_begin    = key_begin_reg;
            cur_key_finish   = key_finish_reg;
            cur_value_begin  = value_begin_reg;
            cur_value_finish = value_finish_reg;
        end
    end

    always_comb begin
        if (cur_mlen == 3'd3 && cur_mchars[23:0] == WORD_GET) begin
            method_class = M_GET;
        end else if (cur_mlen == 3'd4 && cur_mchars == WORD_HEAD) begin
            method_class = M_HEAD;
        end else if (cur_mlen == 3'd4 && cur_mchars == WORD_POST) begin
            method_class = M_POST;
        end else begin
            method_class = M_UNKNOWN;
        end
    end

    always_comb begin
        state_next        = cur_state;
        offset_next       = off + 12'd1;
        mchars_next       = cur_mchars;
        mlen_next         = cur_mlen;
        mkind_next        = cur_mkind;
        uri_begin_next    = cur_uri_begin;
        uri_finish_next   = cur_uri_finish;
        major_next        = cur_major;
        minor_next        = cur_minor;
        key_begin_next    = cur_key_begin;
        key_finish_next   = cur_key_finish;
        value_begin_next  = cur_value_begin;
        value_finish_next = cur_value_finish;
        emit              = 1'b0;
        emit_kind         = EV_LINE;

        unique case (cur_state) inside
            S_START: begin
                if (c == CH_CR || c == CH_LF || c == CH_SP) begin
                end else if (!is_upper) begin
                    emit = 1'b1; emit_kind = EV_BAD_REQUEST;
                end else begin
                    mchars_next = {24'd0, c};
                    mlen_next   = 3'd1;
                    state_next  = S_METHOD;
                end
            end
            S_METHOD: begin
                if (c == CH_SP) begin
                    mkind_next = method_class;
                    state_next = S_SP_URI;
                end else if (!is_upper) begin
                    emit = 1'b1; emit_kind = EV_BAD_METHOD;
                end else begin
                    mchars_next = {cur_mchars[23:0], c};
                    if (cur_mlen < 3'd7) begin
                        mlen_next = cur_mlen + 3'd1;
                    end
                end
            end
            S_SP_URI: begin
                if (c == CH_SLASH) begin
                    uri_begin_next = off + 12'd1;
                    state_next     = S_URI;
                end else if (c != CH_SP) begin
                    emit = 1'b1; emit_kind = EV_BAD_REQUEST;
                end
            end
            S_URI: begin
                if (c == CH_SP) begin
                    uri_finish_next = off;
                    state_next      = S_VH;
                end
            end
            S_VH: begin
                if (c == CH_H) begin
                    state_next = S_VHT;
                end else if (c != CH_SP) begin
                    emit = 1'b1; emit_kind = EV_BAD_REQUEST;
                end
            end
            S_VHT: begin
                if (c == CH_T) begin
                    state_next = S_VHTT;
                end else begin
                    emit = 1'b1; emit_kind = EV_BAD_REQUEST;
                end
            end
            S_VHTT: begin
                if (c == CH_T) begin
                    state_next = S_VHTTP;
                end else begin
                    emit = 1'b1; emit_kind = EV_BAD_REQUEST;
                end
            end
            S_VHTTP: begin
                if (c == CH_P) begin
                    state_next = S_VSLASH;
                end else begin
                    emit = 1'b1; emit_kind = EV_BAD_REQUEST;
                end
            end
            S_VSLASH: begin
                if (c == CH_SLASH) begin
                    state_next = S_MAJ_FIRST;
                end else begin
                    emit = 1'b1; emit_kind = EV_BAD_REQUEST;
                end
            end
            S_MAJ_FIRST: begin
                if (is_digit) begin
                    major_next = ver_acc(10'd0, c);
                    state_next = S_MAJ;
                end else begin
                    emit = 1'b1; emit_kind = EV_BAD_REQUEST;
                end
            end
            S_MAJ: begin
                if (c == CH_DOT) begin
                    state_next = S_MIN_FIRST;
                end else if (is_digit) begin
                    major_next = ver_acc(cur_major, c);
                end else begin
                    emit = 1'b1; emit_kind = EV_BAD_REQUEST;
                end
            end
            S_MIN_FIRST: begin
                if (is_digit) begin
                    minor_next = ver_acc(10'd0, c);
                    state_next = S_MIN;
                end else begin
                    emit = 1'b1; emit_kind = EV_BAD_REQUEST;
                end
            end
            S_MIN, S_SP_AFTER: begin
                if (cur_state == S_MIN && is_digit) begin
                    minor_next = ver_acc(cur_minor, c);
                end else if (c == CH_SP) begin
                    state_next = S_SP_AFTER;
                end else if (c == CH_CR) begin
                    state_next = S_ALMOST;
                end else if (c == CH_LF) begin
                    emit = 1'b1; emit_kind = EV_LINE;
                end else begin
                    emit = 1'b1; emit_kind = EV_BAD_REQUEST;
                end
            end
            S_ALMOST: begin
                emit      = 1'b1;
                emit_kind = (c == CH_LF) ? EV_LINE : EV_BAD_REQUEST;
            end
            S_LINE: begin
                if (c == CH_CR) begin
                    state_next = S_CRLFCR;
                end else if (c == CH_LF) begin
                    emit = 1'b1; emit_kind = EV_END;
                end else begin
                    key_begin_next = off;
                    state_next     = S_KEY;
                end
            end
            S_KEY: begin
                if (c == CH_SP) begin
                    key_finish_next = off;
                    state_next      = S_SP_COLON;
                end else if (c == CH_COLON) begin
                    key_finish_next = off;
                    state_next      = S_SP_VALUE;
                end
            end
            S_SP_COLON: begin
                if (c == CH_COLON) begin
                    state_next = S_SP_VALUE;
                end else if (c != CH_SP) begin
                    emit = 1'b1; emit_kind = EV_BAD_HEADER;
                end
            end
            S_SP_VALUE, S_VALUE: begin
                if (cur_state == S_SP_VALUE && c == CH_SP) begin
                end else begin
                    if (cur_state == S_SP_VALUE) begin
                        value_begin_next = off;
                        state_next       = S_VALUE;
                    end
                    if (c == CH_CR) begin
                        value_finish_next = off;
                        state_next        = S_CR;
                    end else if (c == CH_LF) begin
                        value_finish_next = off;
                        emit = 1'b1; emit_kind = EV_HEADER;
                    end
                end
            end
            S_CR: begin
                emit      = 1'b1;
                emit_kind = (c == CH_LF) ? EV_HEADER : EV_BAD_HEADER;
            end
            S_CRLFCR: begin
                emit      = 1'b1;
                emit_kind = (c == CH_LF) ? EV_END : EV_BAD_HEADER;
            end
            S_DONE: begin
            end
            default: begin
                state_next = S_ERROR;
            end
        endcase

        if (emit) begin
            unique case (emit_kind) inside
                EV_LINE:   state_next = S_LINE;
                EV_HEADER: state_next = S_LINE;
                EV_END:    state_next = S_DONE;
                default:   state_next = S_ERROR;
            endcase
        end
    end

    always_comb begin
        res       = '0;
        res.valid = emit;
        res.data.event_kind = emit_kind;
        case (emit_kind)
            EV_LINE: begin
                res.data.method_code   = mkind_next;
                res.data.first_start   = uri_begin_next;
                res.data.first_end     = uri_finish_next;
                res.data.version_major = major_next;
                res.data.version_minor = minor_next;
            end
            EV_HEADER: begin
                res.data.first_start  = key_begin_next;
                res.data.first_end    = key_finish_next;
                res.data.second_start = value_begin_next;
                res.data.second_end   = value_finish_next;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_START;
            offset_reg       <= '0;
            mchars_reg       <= '0;
            mlen_reg         <= '0;
            mkind_reg        <= M_UNKNOWN;
            uri_begin_reg    <= '0;
            uri_finish_reg   <= '0;
            major_reg        <= '0;
            minor_reg        <= '0;
            key_begin_reg    <= '0;
            key_finish_reg   <= '0;
            value_begin_reg  <= '0;
            value_finish_reg <= '0;
        end else if (en) begin
            state_reg        <= state_next;
            offset_reg       <= offset_next;
            mchars_reg       <= mchars_next;
            mlen_reg         <= mlen_next;
            mkind_reg        <= mkind_next;
            uri_begin_reg    <= uri_begin_next;
            uri_finish_reg   <= uri_finish_next;
            major_reg        <= major_next;
            minor_reg        <= minor_next;
            key_begin_reg    <= key_begin_next;
            key_finish_reg   <= key_finish_next;
            value_begin_reg  <= value_begin_next;
            value_finish_reg <= value_finish_next;
        end
    end

endmodule

/* rtl/http_request_head_parser.sv */
// Channel   Ports                     Payload
// input     s_valid s_ready s_data    hrp_pkg::in_t  (byte_in, restart)
// result    m_valid m_ready m_data    hrp_pkg::out_t (event and offsets)
//
// One byte per cycle unless the output stalls; a byte is parsed in the cycle it
// leaves the input register, and its result (if any) shows the next cycle.
// The parse step is a single pass through the state logic, held back only by a
// result waiting in the output register.
// aresetn (synchronous) clears both stage valids and the parser to the request line start.
`include "http_request_head_parser_defines.svh"

module http_request_head_parser (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  hrp_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output hrp_pkg::out_t m_data
);
    import hrp_pkg::*;

    logic  in_valid_reg, in_valid_next;
    in_t   in_data_reg;
    logic  out_valid_reg, out_valid_next;
    out_t  out_data_reg;
    logic  advance;
    res_t  res;

    assign advance       = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready       = !in_valid_reg || advance;
    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !advance);
    assign out_valid_next = advance ? res.valid : (out_valid_reg && !m_ready);

    hrp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .item    (in_data_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold payloads until replaced
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance && res.valid) begin
            out_data_reg <= res.data;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    `HRP_ASSERT_NOW(a_kind_range, m_valid, m_data.event_kind <= EV_BAD_HEADER, "event kind out of range")
    `HRP_ASSERT_NOW(a_line_only_fields, m_valid && m_data.event_kind != EV_LINE, m_data.method_code == M_UNKNOWN && m_data.version_major == 10'd0 && m_data.version_minor == 10'd0, "line fields set on other event")
    `HRP_ASSERT_NEXT(a_hold_pending_byte, in_valid_reg && out_valid_reg && !m_ready, in_valid_reg, "pending byte lost under stall")
    `HRP_ASSERT_NOW(a_ready_only_when_full, !s_ready, in_valid_reg && out_valid_reg, "input stalled without cause")

endmodule
